@@ rtl/assert_macros.svh @@
// Assertion macros shared by the nearest-landmark association RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, skipped while reset is asserted.
`define NLA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("nla assertion failed");

// Clocked check that also holds during reset.
`define NLA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("nla assertion failed");

`else

`define NLA_ASSERT(lbl, clk, rstn, prop)
`define NLA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/nla_pkg.sv @@
// Shared types and constants for the nearest-landmark association block.
package nla_pkg;

    localparam int unsigned NLA_MAX_LANDMARKS = 64;
    localparam int unsigned COORD_W           = 24;
    localparam int unsigned DIFF_W            = COORD_W + 1;
    localparam int unsigned DIST_W            = 50;
    localparam int unsigned IDX_OUT_W         = 6;
    localparam int unsigned KIND_W            = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic obs_load;
        logic out_load;
        logic out_empty;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/nla_ram.sv @@
// Generic single-port RAM with registered read data.
module nla_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/nla_ctrl.sv @@
// Controller FSM: table count, scan sequencing and result hand-off.
`include "assert_macros.svh"

module nla_ctrl #(
    parameter int unsigned MAX_LANDMARKS = nla_pkg::NLA_MAX_LANDMARKS,
    parameter int unsigned IW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1,
    parameter int unsigned CW = $clog2(MAX_LANDMARKS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [nla_pkg::KIND_W-1:0]    s_kind,
    output nla_pkg::dp_cmd_t              cmd,
    output logic [IW-1:0]                 addr,
    input  nla_pkg::dp_status_t           sts
);
    import nla_pkg::*;

    ctrl_state_t   state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic          accept;
    logic          not_full;
    logic          last_entry;

    assign accept     = s_valid && (state_reg == ST_IDLE);
    assign not_full   = count_reg < CW'(MAX_LANDMARKS);
    assign last_entry = CW'(scan_reg) == (count_reg - CW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_CLEAR: begin
                            count_next = '0;
                        end
                        KIND_APPEND: begin
                            if (not_full) begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        KIND_QUERY: begin
                            scan_next  = '0;
                            state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (last_entry) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_next = scan_reg + IW'(1);
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd           = '0;
        addr          = count_reg[IW-1:0];
        cmd.out_empty = (count_reg == '0);
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.wr_en    = accept && (s_kind == KIND_APPEND) && not_full;
                cmd.obs_load = accept && (s_kind == KIND_QUERY);
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                addr      = scan_reg;
            end
            ST_DRAIN: begin
                cmd.rd_en = 1'b0;
            end
            ST_DONE: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    `NLA_ASSERT(a_rd_in_table, aclk, aresetn, cmd.rd_en |-> (CW'(addr) < count_reg))
    `NLA_ASSERT(a_load_when_free, aclk, aresetn, cmd.out_load |-> sts.out_free)
    `NLA_ASSERT(a_no_write_in_scan, aclk, aresetn, (state_reg != ST_IDLE) |-> !cmd.wr_en)
    `NLA_ASSERT(a_count_bounded, aclk, aresetn, count_reg <= CW'(MAX_LANDMARKS))

endmodule

@@ rtl/nla_dp.sv @@
// Datapath: landmark RAM, distance pipeline, running minimum and result register.
`include "assert_macros.svh"

module nla_dp #(
    parameter int unsigned MAX_LANDMARKS = nla_pkg::NLA_MAX_LANDMARKS,
    parameter int unsigned IW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  nla_pkg::dp_cmd_t                      cmd,
    input  logic [IW-1:0]                         addr,
    output nla_pkg::dp_status_t                   sts,
    input  logic signed [nla_pkg::COORD_W-1:0]    s_point_x,
    input  logic signed [nla_pkg::COORD_W-1:0]    s_point_y,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [nla_pkg::IDX_OUT_W-1:0]         m_nearest_index,
    output logic [nla_pkg::DIST_W-1:0]            m_min_distance_sq,
    output logic                                  m_table_empty
);
    import nla_pkg::*;

    logic [2*COORD_W-1:0]       rdata;
    logic signed [COORD_W-1:0]  lm_x, lm_y;
    logic signed [COORD_W-1:0]  obs_x_reg, obs_y_reg;

    logic                       v1_reg, v2_reg, v3_reg;
    logic [IW-1:0]              idx1_reg, idx2_reg, idx3_reg;

    logic signed [DIFF_W-1:0]   dx, dy;
    logic [DIFF_W-1:0]          mag_x_next, mag_y_next;
    logic [DIFF_W-1:0]          mag_x_reg, mag_y_reg;
    logic [2*DIFF_W-1:0]        prod_x, prod_y;
    logic [DIST_W-1:0]          sq_x_reg, sq_y_reg;
    logic [DIST_W-1:0]          sum;

    logic [IW-1:0]              best_idx_reg;
    logic [DIST_W-1:0]          best_d_reg;
    logic                       take;

    logic                       m_valid_reg;
    logic [IDX_OUT_W-1:0]       m_idx_reg;
    logic [DIST_W-1:0]          m_dist_reg;
    logic                       m_empty_reg;
    logic [IW+IDX_OUT_W-1:0]    idx_ext;

    nla_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_LANDMARKS),
        .AW    (IW)
    ) u_ram (
        .clk   (aclk),
        .we    (cmd.wr_en),
        .re    (cmd.rd_en),
        .addr  (addr),
        .wdata ({s_point_x, s_point_y}),
        .rdata (rdata)
    );

    assign lm_x = rdata[2*COORD_W-1:COORD_W];
    assign lm_y = rdata[COORD_W-1:0];

    always_comb begin
        dx         = DIFF_W'(lm_x) - DIFF_W'(obs_x_reg);
        dy         = DIFF_W'(lm_y) - DIFF_W'(obs_y_reg);
        mag_x_next = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        mag_y_next = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        prod_x     = mag_x_reg * mag_x_reg;
        prod_y     = mag_y_reg * mag_y_reg;
        sum        = sq_x_reg + sq_y_reg;
        take       = v3_reg && ((idx3_reg == '0) || (sum < best_d_reg));
        idx_ext    = {{IDX_OUT_W{1'b0}}, best_idx_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.obs_load) begin
            obs_x_reg <= s_point_x;
            obs_y_reg <= s_point_y;
        end
        idx1_reg  <= addr;
        idx2_reg  <= idx1_reg;
        idx3_reg  <= idx2_reg;
        mag_x_reg <= mag_x_next;
        mag_y_reg <= mag_y_next;
        sq_x_reg  <= prod_x[DIST_W-1:0];
        sq_y_reg  <= prod_y[DIST_W-1:0];
        if (take) begin
            best_idx_reg <= idx3_reg;
            best_d_reg   <= sum;
        end
        if (cmd.out_load) begin
            m_idx_reg   <= cmd.out_empty ? '0 : idx_ext[IDX_OUT_W-1:0];
            m_dist_reg  <= cmd.out_empty ? '0 : best_d_reg;
            m_empty_reg <= cmd.out_empty;
        end
    end

    assign sts.pipe_busy   = v1_reg || v2_reg || v3_reg;
    assign sts.out_free    = !m_valid_reg || m_ready;

    assign m_valid           = m_valid_reg;
    assign m_nearest_index   = m_idx_reg;
    assign m_min_distance_sq = m_dist_reg;
    assign m_table_empty     = m_empty_reg;

    `NLA_ASSERT(a_load_after_drain, aclk, aresetn, cmd.out_load |-> !sts.pipe_busy)
    `NLA_ASSERT(a_first_entry_taken, aclk, aresetn, (v3_reg && (idx3_reg == '0)) |=> (best_d_reg == $past(sum)))
    `NLA_ASSERT(a_pipe_tags_follow, aclk, aresetn, v2_reg |-> (idx2_reg == $past(idx1_reg)))

endmodule

@@ rtl/nearest_landmark_association_core.sv @@
// Top level of the nearest-landmark association block.
//
// Input channel (s_valid/s_ready): one request per item. s_kind selects clear
// table, append landmark (s_point_x/s_point_y) or query with an observed point.
// Kind 3 is accepted and ignored. Appends to a full table are dropped.
// Result channel (m_valid/m_ready): one result per query, none otherwise.
// A result carries the index of the first closest landmark, its squared
// distance (16 fraction bits) and m_table_empty; an empty table yields index 0
// and distance 0.
// Clear and append are handled in the idle state. A query reads the RAM once
// per stored landmark, then passes through three pipeline stages (RAM data,
// differences, squares) and the compare drain before m_valid rises; the next
// request is taken in the cycle m_valid rises at the earliest.
// An empty-table query skips the scan and the pipeline.
// The result sits in an output register; the next request is accepted while
// it waits. A query that finishes while the receiver stalls holds until the
// register is taken. Reset (aresetn low, synchronous) empties the table and
// drops any pending result; the landmark RAM itself is not cleared.
module nearest_landmark_association_core #(
    parameter int unsigned MAX_LANDMARKS = nla_pkg::NLA_MAX_LANDMARKS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [nla_pkg::KIND_W-1:0]            s_kind,
    input  logic signed [nla_pkg::COORD_W-1:0]    s_point_x,
    input  logic signed [nla_pkg::COORD_W-1:0]    s_point_y,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [nla_pkg::IDX_OUT_W-1:0]         m_nearest_index,
    output logic [nla_pkg::DIST_W-1:0]            m_min_distance_sq,
    output logic                                  m_table_empty
);
    import nla_pkg::*;

    localparam int unsigned IW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int unsigned CW = $clog2(MAX_LANDMARKS + 1);

    dp_cmd_t       cmd;
    dp_status_t    sts;
    logic [IW-1:0] addr;

    nla_ctrl #(
        .MAX_LANDMARKS (MAX_LANDMARKS),
        .IW            (IW),
        .CW            (CW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .cmd     (cmd),
        .addr    (addr),
        .sts     (sts)
    );

    nla_dp #(
        .MAX_LANDMARKS (MAX_LANDMARKS),
        .IW            (IW)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .addr              (addr),
        .sts               (sts),
        .s_point_x         (s_point_x),
        .s_point_y         (s_point_y),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_nearest_index   (m_nearest_index),
        .m_min_distance_sq (m_min_distance_sq),
        .m_table_empty     (m_table_empty)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for nearest_landmark_association_core with randomized requests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nla_pkg::*;

    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam int unsigned TABLE_DEPTH = NLA_MAX_LANDMARKS;
    localparam int REQUEST_TARGET = 1900;
    localparam int CALM_TAIL = 250;
    localparam int HANG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 20;
    localparam int PRINT_CAP = 40;
    localparam logic [COORD_W-1:0] C_MAX = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] C_MIN = 24'h800000;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } request_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] index;
        logic [DIST_W-1:0]    distance;
        logic                 is_empty;
    } association_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [KIND_W-1:0]         s_kind = '0;
    logic signed [COORD_W-1:0] s_point_x = '0;
    logic signed [COORD_W-1:0] s_point_y = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [IDX_OUT_W-1:0]      m_nearest_index;
    logic [DIST_W-1:0]         m_min_distance_sq;
    logic                      m_table_empty;

    nearest_landmark_association_core dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    request_t     pending_requests[$];
    association_t awaited_results[$];
    request_t     in_flight;

    // predicted landmark table
    logic [COORD_W-1:0] table_x[TABLE_DEPTH];
    logic [COORD_W-1:0] table_y[TABLE_DEPTH];
    int unsigned        table_count = 0;

    int  planned = 0;
    int  requests_accepted = 0;
    int  results_checked = 0;
    int  empty_queries = 0;
    int  full_queries = 0;
    int  appends_dropped = 0;
    int  ignored_requests = 0;
    int  mismatches = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;
    bit  hung = 1'b0;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s got %0d expected %0d (result %0d)",
                     $realtime, what, got, want, results_checked);
        mismatches++;
    endtask

    function automatic logic [DIST_W-1:0] squared_distance(logic [COORD_W-1:0] ax,
            logic [COORD_W-1:0] ay, logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by);
        longint dx;
        longint dy;
        dx = longint'($signed(ax)) - longint'($signed(bx));
        dy = longint'($signed(ay)) - longint'($signed(by));
        return DIST_W'(dx * dx + dy * dy);
    endfunction

    // update the predicted table and queue the expected association for a query
    task automatic track_request(request_t r);
        association_t res;
        logic [DIST_W-1:0] d;
        int unsigned j;
        case (r.kind)
            KIND_CLEAR: table_count = 0;
            KIND_APPEND: begin
                if (table_count < TABLE_DEPTH) begin
                    table_x[table_count] = r.x;
                    table_y[table_count] = r.y;
                    table_count++;
                end else begin
                    appends_dropped++;
                end
            end
            KIND_QUERY: begin
                res = '0;
                res.is_empty = (table_count == 0);
                if (table_count == 0) empty_queries++;
                if (table_count == TABLE_DEPTH) full_queries++;
                for (j = 0; j < table_count; j++) begin
                    d = squared_distance(table_x[j], table_y[j], r.x, r.y);
                    if (j == 0 || d < res.distance) begin
                        res.index = IDX_OUT_W'(j);
                        res.distance = d;
                    end
                end
                awaited_results.insert(awaited_results.size(), res);
            end
            default: ignored_requests++;
        endcase
    endtask

    task automatic push_request(logic [KIND_W-1:0] k, logic [COORD_W-1:0] x,
                                logic [COORD_W-1:0] y);
        request_t r;
        r.kind = k;
        r.x = x;
        r.y = y;
        pending_requests.insert(pending_requests.size(), r);
        if (k != KIND_IGNORED) planned++;
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(int style);
        case (style)
            0, 1: return COORD_W'($urandom);
            2: return COORD_W'($urandom_range(0, 255)) - COORD_W'(128);
            default: begin
                case ($urandom_range(0, 3))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    task automatic build_stimulus();
        point_t seq_points[$];
        point_t p;
        int style;
        int n;
        int i;
        push_request(KIND_QUERY, '0, '0);
        push_request(KIND_IGNORED, C_MAX, C_MIN);
        push_request(KIND_APPEND, C_MAX, C_MAX);
        push_request(KIND_APPEND, C_MIN, C_MIN);
        push_request(KIND_QUERY, C_MIN, C_MIN);
        push_request(KIND_QUERY, C_MAX, C_MIN);  // equal distances, first entry wins
        push_request(KIND_QUERY, '0, '0);
        push_request(KIND_APPEND, C_MAX, C_MAX);
        push_request(KIND_QUERY, C_MAX, C_MAX);  // duplicate at zero distance
        push_request(KIND_APPEND, 24'h555555, 24'hAAAAAA);
        push_request(KIND_APPEND, 24'hAAAAAA, 24'h555555);
        push_request(KIND_QUERY, '1, 24'h000001);
        push_request(KIND_QUERY, 24'h555555, 24'hAAAAAA);
        push_request(KIND_CLEAR, '0, '0);
        push_request(KIND_QUERY, C_MAX, C_MAX);  // old entries no longer valid
        push_request(KIND_APPEND, C_MAX, C_MAX);
        push_request(KIND_QUERY, C_MIN, C_MIN);  // largest distance
        push_request(KIND_IGNORED, '1, '1);
        push_request(KIND_CLEAR, C_MIN, C_MAX);
        push_request(KIND_QUERY, C_MIN, C_MAX);

        while (planned < REQUEST_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    push_request(KIND_W'($urandom_range(0, 3)), COORD_W'($urandom),
                                 COORD_W'($urandom));
            end else begin
                style = $urandom_range(0, 3);
                if ($urandom_range(0, 3) != 0)
                    push_request(KIND_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
                seq_points.delete();
                case ($urandom_range(0, 19))
                    0: n = $urandom_range(60, 72);
                    1: n = 0;
                    default: n = $urandom_range(1, 10);
                endcase
                for (i = 0; i < n; i++) begin
                    if (seq_points.size() != 0 && $urandom_range(0, 5) == 0)
                        p = seq_points[$urandom_range(0, seq_points.size() - 1)];
                    else
                        p = '{pick_coord(style), pick_coord(style)};
                    push_request(KIND_APPEND, p.x, p.y);
                    seq_points.insert(seq_points.size(), p);
                end
                repeat ($urandom_range(1, 5)) begin
                    if (seq_points.size() != 0 && $urandom_range(0, 2) == 0) begin
                        p = seq_points[$urandom_range(0, seq_points.size() - 1)];
                        p.x = p.x + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
                        p.y = p.y + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
                    end else begin
                        p = '{pick_coord(style), pick_coord(style)};
                    end
                    push_request(KIND_QUERY, p.x, p.y);
                end
            end
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                track_request(in_flight);
                requests_accepted++;
            end
            if (!s_valid || s_ready) begin
                calm = (pending_requests.size() < CALM_TAIL);
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 16);
                    s_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    in_flight = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= in_flight.kind;
                    s_point_x <= in_flight.x;
                    s_point_y <= in_flight.y;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        association_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result, index", m_nearest_index, 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_nearest_index !== want.index)
                        report_mismatch("nearest_index", m_nearest_index, want.index);
                    if (m_min_distance_sq !== want.distance)
                        report_mismatch("min_distance_sq", m_min_distance_sq, want.distance);
                    if (m_table_empty !== want.is_empty)
                        report_mismatch("table_empty", m_table_empty, want.is_empty);
                end
                results_checked++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: nothing moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) hung = 1'b1;
    end

    initial begin
        int total;
        build_stimulus();
        total = pending_requests.size();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (requests_accepted < total && !hung) @(posedge aclk);
        while (awaited_results.size() != 0 && !hung) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (hung) $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", 0, awaited_results.size());
        $display("summary: %0d requests accepted (%0d ignored), %0d query results checked",
                 requests_accepted, ignored_requests, results_checked);
        $display("summary: %0d on an empty table, %0d on a full table, %0d appends dropped",
                 empty_queries, full_queries, appends_dropped);
        if (mismatches == 0 && !hung && awaited_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
